FILE: design/clr_pkg.sv
// Shared types and constants for the clipped line rasterizer.
// Used by every module of the block; depends on nothing.
package clr_pkg;

    // Default parameter values for the top level.
    localparam int DEF_SCREEN_SIZE = 128;
    localparam int DEF_COORD_BITS  = 16;

    // Fixed widths of the configuration registers and the colour path.
    localparam int CAM_BITS     = 16;
    localparam int CLIP_BITS    = 8;
    localparam int PAL_BITS     = 64;
    localparam int PEN_BITS     = 8;
    localparam int COL_BITS     = 4;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_PALETTE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_X    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_Y    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [PAL_BITS-1:0]  PALETTE_RESET     = 64'hFEDC_BA98_7654_3210;
    localparam logic [CLIP_BITS-1:0] CLIP_RIGHT_RESET  = 8'd128;
    localparam logic [CLIP_BITS-1:0] CLIP_BOTTOM_RESET = 8'd128;

    // Input word kinds carried on tuser.
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic        [PAL_BITS-1:0]  palette;
        logic signed [CAM_BITS-1:0]  camera_x;
        logic signed [CAM_BITS-1:0]  camera_y;
        logic        [CLIP_BITS-1:0] clip_left;
        logic        [CLIP_BITS-1:0] clip_top;
        logic        [CLIP_BITS-1:0] clip_right;
        logic        [CLIP_BITS-1:0] clip_bottom;
    } clr_cfg_t;

endpackage

FILE: design/clipped_line_rasterizer.sv
// Clipped line rasterizer: a command word loads a line, each tick word while a line is loaded yields one pixel.
// An accepted word passes through the input register, then the result register holds its pixel word.
// Throughput is one word per cycle while the output is not stalled; the line state updates once per accepted word.
// Commands and idle ticks produce no output word.
// Reset (rst_n, asynchronous, active low) clears the line state and loads the
// identity palette, zero camera and a full-screen clip rectangle.
module clipped_line_rasterizer #(
    parameter int SCREEN_SIZE = clr_pkg::DEF_SCREEN_SIZE,
    parameter int COORD_BITS  = clr_pkg::DEF_COORD_BITS,
    parameter int SCR_W       = $clog2(SCREEN_SIZE),
    parameter int IN_W        = ((4 * COORD_BITS + clr_pkg::PEN_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((2 * SCR_W + clr_pkg::COL_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input words.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_x, start_y, end_x, end_y, pen_colour, from the lowest bit up.
    input  logic [IN_W-1:0]                  s_axis_tdata,
    // kind.
    input  logic                             s_axis_tuser,
    // Pixel words.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // screen_x, screen_y, pixel_colour, from the lowest bit up.
    output logic [OUT_W-1:0]                 m_axis_tdata,
    // visible.
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [clr_pkg::PAL_BITS-1:0]     cfg_data
);
    import clr_pkg::*;

    localparam int PIX_W = 2 * SCR_W + COL_BITS;

    clr_cfg_t cfg;

    logic                         in_valid_reg;
    logic                         in_kind_reg;
    logic signed [COORD_BITS-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [PEN_BITS-1:0]          pen_reg;

    logic                         advance, take;
    logic                         emit, fin;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [COL_BITS-1:0]          held_colour;
    logic [SCR_W-1:0]             screen_x, screen_y;
    logic [COL_BITS-1:0]          pixel_colour;
    logic                         visible;

    logic                         out_valid_reg;
    logic [PIX_W-1:0]             out_pix_reg;
    logic                         out_vis_reg, out_last_reg;

    // Stage 1 moves on whenever the result register is free or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign take          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    clr_config_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg <= s_axis_tuser;
            start_x_reg <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
            start_y_reg <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
            end_x_reg   <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
            end_y_reg   <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
            pen_reg     <= s_axis_tdata[4*COORD_BITS +: PEN_BITS];
        end
    end

    clr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item_take   (take),
        .item_kind   (in_kind_reg),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .end_x       (end_x_reg),
        .end_y       (end_y_reg),
        .pen_colour  (pen_reg),
        .emit        (emit),
        .fin         (fin),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .held_colour (held_colour)
    );

    clr_pixel_map #(
        .SCREEN_SIZE (SCREEN_SIZE),
        .COORD_BITS  (COORD_BITS),
        .SCR_W       (SCR_W)
    ) u_map (
        .cfg          (cfg),
        .cur_x        (cur_x),
        .cur_y        (cur_y),
        .held_colour  (held_colour),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .pixel_colour (pixel_colour),
        .visible      (visible)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg && emit;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_pix_reg  <= {pixel_colour, screen_y, screen_x};
            out_vis_reg  <= visible;
            out_last_reg <= fin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-PIX_W){1'b0}}, out_pix_reg};
    assign m_axis_tuser  = out_vis_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: design/clr_config_regs.sv
// Configuration register file of the clipped line rasterizer.
// Depends on clr_pkg for register indexes, reset values and clr_cfg_t.
module clr_config_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [clr_pkg::PAL_BITS-1:0]     cfg_data,
    output clr_pkg::clr_cfg_t               cfg
);
    import clr_pkg::*;

    clr_cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.palette     <= PALETTE_RESET;
            cfg_reg.camera_x    <= '0;
            cfg_reg.camera_y    <= '0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= CLIP_RIGHT_RESET;
            cfg_reg.clip_bottom <= CLIP_BOTTOM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PALETTE:     cfg_reg.palette     <= cfg_data;
                REG_CAMERA_X:    cfg_reg.camera_x    <= cfg_data[CAM_BITS-1:0];
                REG_CAMERA_Y:    cfg_reg.camera_y    <= cfg_data[CAM_BITS-1:0];
                REG_CLIP_LEFT:   cfg_reg.clip_left   <= cfg_data[CLIP_BITS-1:0];
                REG_CLIP_TOP:    cfg_reg.clip_top    <= cfg_data[CLIP_BITS-1:0];
                REG_CLIP_RIGHT:  cfg_reg.clip_right  <= cfg_data[CLIP_BITS-1:0];
                REG_CLIP_BOTTOM: cfg_reg.clip_bottom <= cfg_data[CLIP_BITS-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: design/clr_stepper.sv
// Line state and one-pixel Bresenham step of the clipped line rasterizer.
// Depends on clr_pkg for the word kind codes and widths.
module clr_stepper #(
    parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_take,
    input  logic                              item_kind,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    input  logic [clr_pkg::PEN_BITS-1:0]      pen_colour,
    output logic                              emit,
    output logic                              fin,
    output logic signed [COORD_BITS-1:0]      cur_x,
    output logic signed [COORD_BITS-1:0]      cur_y,
    output logic [clr_pkg::COL_BITS-1:0]      held_colour
);
    import clr_pkg::*;

    localparam int DX_W  = COORD_BITS + 1;
    localparam int NDY_W = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = COORD_BITS + 4;

    typedef enum logic [1:0] {
        MODE_ROW,
        MODE_COL,
        MODE_GEN
    } line_mode_t;

    logic                     busy_reg, busy_next;
    line_mode_t               mode_reg, mode_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] stop_x_reg, stop_x_next;
    logic signed [COORD_BITS-1:0] stop_y_reg, stop_y_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [DX_W-1:0]          dx_reg, dx_next;
    logic signed [NDY_W-1:0]  ndy_reg, ndy_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;
    logic [COL_BITS-1:0]      col_reg, col_next;

    // Command set-up terms.
    logic                     x_lt, y_lt;
    logic signed [DX_W-1:0]   diff_x, diff_y;
    logic [DX_W-1:0]          abs_x, abs_y;

    // Step terms.
    logic signed [E2_W-1:0]   e2, ndy_ext, dx_ext, err_sum;
    logic                     take_x, take_y;

    assign emit        = item_valid && (item_kind == KIND_TICK) && busy_reg;
    assign fin         = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
    assign cur_x       = cur_x_reg;
    assign cur_y       = cur_y_reg;
    assign held_colour = col_reg;

    // Endpoint ordering and absolute deltas for a new command.
    always_comb
    begin
        x_lt   = start_x < end_x;
        y_lt   = start_y < end_y;
        diff_x = DX_W'(end_x) - DX_W'(start_x);
        diff_y = DX_W'(end_y) - DX_W'(start_y);
        abs_x  = diff_x[DX_W-1] ? DX_W'(-diff_x) : DX_W'(diff_x);
        abs_y  = diff_y[DX_W-1] ? DX_W'(-diff_y) : DX_W'(diff_y);
    end

    // Error decisions for a general-line step.
    always_comb
    begin
        e2      = {err_reg, 1'b0};
        ndy_ext = E2_W'(ndy_reg);
        dx_ext  = {{(E2_W-DX_W){1'b0}}, dx_reg};
        take_x  = e2 >= ndy_ext;
        take_y  = e2 <= dx_ext;
        err_sum = E2_W'(err_reg) + (take_x ? ndy_ext : '0) + (take_y ? dx_ext : '0);
    end

    // Next line state for a command or a tick.
    always_comb
    begin
        busy_next   = busy_reg;
        mode_next   = mode_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        stop_x_next = stop_x_reg;
        stop_y_next = stop_y_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        ndy_next    = ndy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        col_next    = col_reg;
        if (item_take && (item_kind == KIND_CMD))
        begin
            busy_next = 1'b1;
            col_next  = pen_colour[COL_BITS-1:0];
            if (start_y == end_y)
            begin
                mode_next   = MODE_ROW;
                cur_x_next  = x_lt ? start_x : end_x;
                stop_x_next = x_lt ? end_x : start_x;
                cur_y_next  = start_y;
                stop_y_next = start_y;
            end
            else if (start_x == end_x)
            begin
                mode_next   = MODE_COL;
                cur_y_next  = y_lt ? start_y : end_y;
                stop_y_next = y_lt ? end_y : start_y;
                cur_x_next  = start_x;
                stop_x_next = start_x;
            end
            else
            begin
                mode_next   = MODE_GEN;
                cur_x_next  = start_x;
                cur_y_next  = start_y;
                stop_x_next = end_x;
                stop_y_next = end_y;
                dx_next     = abs_x;
                ndy_next    = -NDY_W'(abs_y);
                sx_neg_next = !x_lt;
                sy_neg_next = !y_lt;
                err_next    = ERR_W'(abs_x) - ERR_W'(abs_y);
            end
        end
        else if (item_take && emit)
        begin
            if (fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_ROW: cur_x_next = cur_x_reg + COORD_BITS'(1);
                    MODE_COL: cur_y_next = cur_y_reg + COORD_BITS'(1);
                    default:
                    begin
                        err_next = err_sum[ERR_W-1:0];
                        if (take_x)
                            cur_x_next = sx_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                                    : cur_x_reg + COORD_BITS'(1);
                        if (take_y)
                            cur_y_next = sy_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                                    : cur_y_reg + COORD_BITS'(1);
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= MODE_ROW;
        end
        else
        begin
            busy_reg <= busy_next;
            mode_reg <= mode_next;
        end
    end

    // Line coordinates and error terms.
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        stop_x_reg <= stop_x_next;
        stop_y_reg <= stop_y_next;
        err_reg    <= err_next;
        dx_reg     <= dx_next;
        ndy_reg    <= ndy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        col_reg    <= col_next;
    end

endmodule

FILE: design/clr_pixel_map.sv
// Camera offset, clip test and palette lookup for one pixel.
// Depends on clr_pkg for clr_cfg_t and the fixed field widths.
module clr_pixel_map #(
    parameter int SCREEN_SIZE = clr_pkg::DEF_SCREEN_SIZE,
    parameter int COORD_BITS  = clr_pkg::DEF_COORD_BITS,
    parameter int SCR_W       = $clog2(SCREEN_SIZE)
) (
    input  clr_pkg::clr_cfg_t            cfg,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic [clr_pkg::COL_BITS-1:0] held_colour,
    output logic [SCR_W-1:0]             screen_x,
    output logic [SCR_W-1:0]             screen_y,
    output logic [clr_pkg::COL_BITS-1:0] pixel_colour,
    output logic                         visible
);
    import clr_pkg::*;

    localparam int SX_W = ((COORD_BITS > CAM_BITS) ? COORD_BITS : CAM_BITS) + 1;
    localparam logic signed [SX_W-1:0] SCR_LIM = SX_W'(SCREEN_SIZE);

    logic signed [SX_W-1:0] sx, sy;
    logic signed [SX_W-1:0] left_ext, top_ext, right_ext, bottom_ext;
    logic                   in_x, in_y;

    // Full-width camera subtraction so the position never wraps.
    always_comb
    begin
        sx = {{(SX_W-COORD_BITS){cur_x[COORD_BITS-1]}}, cur_x}
           - {{(SX_W-CAM_BITS){cfg.camera_x[CAM_BITS-1]}}, cfg.camera_x};
        sy = {{(SX_W-COORD_BITS){cur_y[COORD_BITS-1]}}, cur_y}
           - {{(SX_W-CAM_BITS){cfg.camera_y[CAM_BITS-1]}}, cfg.camera_y};
    end

    // Clip rectangle intersected with the screen.
    always_comb
    begin
        left_ext   = {{(SX_W-CLIP_BITS){1'b0}}, cfg.clip_left};
        top_ext    = {{(SX_W-CLIP_BITS){1'b0}}, cfg.clip_top};
        right_ext  = {{(SX_W-CLIP_BITS){1'b0}}, cfg.clip_right};
        bottom_ext = {{(SX_W-CLIP_BITS){1'b0}}, cfg.clip_bottom};
        in_x    = (sx >= left_ext) && (sx < right_ext) && !sx[SX_W-1] && (sx < SCR_LIM);
        in_y    = (sy >= top_ext) && (sy < bottom_ext) && !sy[SX_W-1] && (sy < SCR_LIM);
        visible = in_x && in_y;
    end

    // Hidden pixels report position zero.
    assign screen_x     = visible ? sx[SCR_W-1:0] : '0;
    assign screen_y     = visible ? sy[SCR_W-1:0] : '0;
    assign pixel_colour = cfg.palette[COL_BITS*held_colour +: COL_BITS];

endmodule

FILE: tb/tb_clipped_line_rasterizer.sv
// Self-checking testbench for the clipped line rasterizer: directed table, then random lines.
// Predicts pixel words from its own stepper or typed rows; depends on clr_pkg and the block.
module tb_clipped_line_rasterizer;
    import clr_pkg::*;

    localparam int SCR_W        = $clog2(DEF_SCREEN_SIZE);
    localparam int IN_W         = ((4 * DEF_COORD_BITS + PEN_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * SCR_W + COL_BITS + 7) / 8) * 8;
    localparam int HALF_PERIOD  = 10;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 170;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 26;

    typedef enum logic [1:0] {LINE_ROW, LINE_COLUMN, LINE_GENERAL} line_mode_t;

    typedef struct packed {
        logic [SCR_W-1:0]    scr_x;
        logic [SCR_W-1:0]    scr_y;
        logic [COL_BITS-1:0] colour;
        logic                vis;
        logic                fin;
    } pixel_t;

    typedef struct packed {
        logic                kind;
        logic [15:0]         x0;
        logic [15:0]         y0;
        logic [15:0]         x1;
        logic [15:0]         y1;
        logic [PEN_BITS-1:0] pen;
        logic                typed;
        pixel_t              want;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_W-1:0]         s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_W-1:0]        m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [PAL_BITS-1:0]     cfg_data;

    // Configuration as the predictor sees it.
    logic [PAL_BITS-1:0]        palette;
    logic signed [CAM_BITS-1:0] cam_x;
    logic signed [CAM_BITS-1:0] cam_y;
    logic [CLIP_BITS-1:0]       clip_l;
    logic [CLIP_BITS-1:0]       clip_t;
    logic [CLIP_BITS-1:0]       clip_r;
    logic [CLIP_BITS-1:0]       clip_b;

    // Line stepper state of the predictor.
    bit                  line_busy;
    line_mode_t          line_mode_q;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic signed [15:0]  stop_x;
    logic signed [15:0]  stop_y;
    logic signed [18:0]  err;
    logic signed [16:0]  run_x;
    logic signed [17:0]  neg_rise;
    bit                  back_x;
    bit                  back_y;
    logic [COL_BITS-1:0] held_pen;

    pixel_t   pending_pixels [$];
    dir_row_t dir_rows [DIR_ROWS];
    int       fail_count;
    int       rx_count;
    int       quiet;
    bit       steady;

    clipped_line_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // A command word picks row, column or general stepping and loads the endpoints.
    function automatic void load_line(input logic signed [15:0] x0, input logic signed [15:0] y0,
                                      input logic signed [15:0] x1, input logic signed [15:0] y1,
                                      input logic [PEN_BITS-1:0] pen);
        longint dx;
        longint dy;
        held_pen  = pen[COL_BITS-1:0];
        line_busy = 1'b1;
        if (y0 == y1)
        begin
            line_mode_q = LINE_ROW;
            pos_x  = (x0 < x1) ? x0 : x1;
            stop_x = (x0 < x1) ? x1 : x0;
            pos_y  = y0;
            stop_y = y0;
        end
        else if (x0 == x1)
        begin
            line_mode_q = LINE_COLUMN;
            pos_y  = (y0 < y1) ? y0 : y1;
            stop_y = (y0 < y1) ? y1 : y0;
            pos_x  = x0;
            stop_x = x0;
        end
        else
        begin
            line_mode_q = LINE_GENERAL;
            pos_x  = x0;
            pos_y  = y0;
            stop_x = x1;
            stop_y = y1;
            dx = (x1 > x0) ? longint'(x1) - longint'(x0) : longint'(x0) - longint'(x1);
            dy = (y1 > y0) ? longint'(y1) - longint'(y0) : longint'(y0) - longint'(y1);
            run_x    = 17'(dx);
            neg_rise = 18'(-dy);
            back_x   = !(x0 < x1);
            back_y   = !(y0 < y1);
            err      = 19'(dx - dy);
        end
    endfunction

    // A tick word emits the current pixel, then steps; returns 0 when no line is loaded.
    function automatic bit raster_tick(output pixel_t px);
        longint sx;
        longint sy;
        longint e2;
        bit     vis;
        px = '0;
        if (!line_busy)
            return 1'b0;
        sx  = longint'(pos_x) - longint'(cam_x);
        sy  = longint'(pos_y) - longint'(cam_y);
        vis = sx >= longint'(clip_l) && sx < longint'(clip_r) &&
              sy >= longint'(clip_t) && sy < longint'(clip_b) &&
              sx >= 0 && sx < DEF_SCREEN_SIZE && sy >= 0 && sy < DEF_SCREEN_SIZE;
        px.scr_x  = vis ? sx[SCR_W-1:0] : '0;
        px.scr_y  = vis ? sy[SCR_W-1:0] : '0;
        px.colour = palette[COL_BITS * held_pen +: COL_BITS];
        px.vis    = vis;
        px.fin    = (pos_x == stop_x) && (pos_y == stop_y);
        if (px.fin)
            line_busy = 1'b0;
        else if (line_mode_q == LINE_ROW)
            pos_x = pos_x + 16'sd1;
        else if (line_mode_q == LINE_COLUMN)
            pos_y = pos_y + 16'sd1;
        else
        begin
            e2 = 2 * longint'(err);
            if (e2 >= longint'(neg_rise))
            begin
                err   = 19'(longint'(err) + longint'(neg_rise));
                pos_x = back_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
            end
            if (e2 <= longint'(run_x))
            begin
                err   = 19'(longint'(err) + longint'(run_x));
                pos_y = back_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
            end
        end
        return 1'b1;
    endfunction

    // Offer one input word after a random gap; on acceptance, predict its pixel word.
    task automatic send_word(input logic kind, input logic [15:0] x0, input logic [15:0] y0,
                             input logic [15:0] x1, input logic [15:0] y1,
                             input logic [PEN_BITS-1:0] pen, input logic typed,
                             input pixel_t want, output bit got);
        int     gap;
        pixel_t px;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {pen, y1, x1, y0, x0};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        got = 1'b0;
        if (kind == KIND_CMD)
            load_line(x0, y0, x1, y1, pen);
        else
        begin
            got = raster_tick(px);
            if (got)
                pending_pixels.push_back(typed ? want : px);
        end
        @(negedge clk);
    endtask

    // Write one configuration register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [PAL_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_PALETTE:     palette = val;
            REG_CAMERA_X:    cam_x   = val[CAM_BITS-1:0];
            REG_CAMERA_Y:    cam_y   = val[CAM_BITS-1:0];
            REG_CLIP_LEFT:   clip_l  = val[CLIP_BITS-1:0];
            REG_CLIP_TOP:    clip_t  = val[CLIP_BITS-1:0];
            REG_CLIP_RIGHT:  clip_r  = val[CLIP_BITS-1:0];
            REG_CLIP_BOTTOM: clip_b  = val[CLIP_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Stop offering words and let the pipeline empty out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One command, then ticks that usually run the line to its end but sometimes stop early.
    task automatic random_line(inout int words);
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        int                 shape;
        int                 ticks;
        bit                 got;
        if ($urandom_range(0, 9) == 0)
        begin
            x0 = 16'($urandom);
            y0 = 16'($urandom);
            x1 = 16'($urandom);
            y1 = 16'($urandom);
        end
        else
        begin
            x0 = clamp16(longint'(cam_x) + int'($urandom_range(0, 190)) - 30);
            y0 = clamp16(longint'(cam_y) + int'($urandom_range(0, 190)) - 30);
            x1 = clamp16(longint'(x0) + int'($urandom_range(0, 48)) - 24);
            y1 = clamp16(longint'(y0) + int'($urandom_range(0, 48)) - 24);
        end
        shape = $urandom_range(0, 9);
        if (shape <= 1 || shape == 4)
            y1 = y0;
        if ((shape >= 2 && shape <= 3) || shape == 4)
            x1 = x0;
        send_word(KIND_CMD, x0, y0, x1, y1, PEN_BITS'($urandom_range(0, 255)), 1'b0, '0, got);
        words++;
        ticks = 0;
        while (line_busy && ticks < 40 && $urandom_range(0, 29) != 0)
        begin
            send_word(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      PEN_BITS'($urandom), 1'b0, '0, got);
            ticks++;
            if (got)
                words++;
        end
        // Occasional extra ticks, past the end of the line if it has finished.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                send_word(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), PEN_BITS'($urandom), 1'b0, '0, got);
                if (got)
                    words++;
            end
        end
    endtask

    // Pixel word receiver: random stalls, one long hold-off, field-by-field check.
    initial
    begin
        int     gap;
        bit     held;
        pixel_t want;
        pixel_t seen;
        m_axis_tready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && rx_count >= HOLD_AT)
            begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            else
                gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            rx_count++;
            seen.scr_x  = m_axis_tdata[SCR_W-1:0];
            seen.scr_y  = m_axis_tdata[2*SCR_W-1:SCR_W];
            seen.colour = m_axis_tdata[2*SCR_W+COL_BITS-1:2*SCR_W];
            seen.vis    = m_axis_tuser;
            seen.fin    = m_axis_tlast;
            if (pending_pixels.size() == 0)
            begin
                $error("pixel word with nothing expected: x=%0d y=%0d", seen.scr_x, seen.scr_y);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (seen.scr_x !== want.scr_x)
                begin
                    $error("screen_x: expected %0d, got %0d", want.scr_x, seen.scr_x);
                    fail_count++;
                end
                if (seen.scr_y !== want.scr_y)
                begin
                    $error("screen_y: expected %0d, got %0d", want.scr_y, seen.scr_y);
                    fail_count++;
                end
                if (seen.colour !== want.colour)
                begin
                    $error("pixel_colour: expected %0d, got %0d", want.colour, seen.colour);
                    fail_count++;
                end
                if (seen.vis !== want.vis)
                begin
                    $error("visible: expected %0d, got %0d", want.vis, seen.vis);
                    fail_count++;
                end
                if (seen.fin !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, seen.fin);
                    fail_count++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: too many cycles without any word moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("[clipped_line_rasterizer] ERROR");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases with new settings.
    initial
    begin
        int                  words;
        bit                  got;
        logic [PAL_BITS-1:0] value;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_CMD;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PALETTE;
        cfg_data      = '0;
        fail_count    = 0;
        rx_count      = 0;
        quiet         = 0;
        steady        = 1'b0;
        palette       = PALETTE_RESET;
        cam_x         = '0;
        cam_y         = '0;
        clip_l        = '0;
        clip_t        = '0;
        clip_r        = CLIP_RIGHT_RESET;
        clip_b        = CLIP_BOTTOM_RESET;
        line_busy     = 1'b0;
        line_mode_q   = LINE_ROW;
        pos_x         = '0;
        pos_y         = '0;
        stop_x        = '0;
        stop_y        = '0;
        err           = '0;
        run_x         = '0;
        neg_rise      = '0;
        back_x        = 1'b0;
        back_y        = 1'b0;
        held_pen      = '0;

        // Directed rows; typed expectations hold for the reset configuration.
        dir_rows = '{
            // tick while idle
            '{KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0},
            // both endpoints equal
            '{KIND_CMD,  16'd5,    16'd7,    16'd5,    16'd7,    8'h13, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd5, 7'd7, 4'd3, 1'b1, 1'b1}},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            // reversed row on the bottom-right screen corner
            '{KIND_CMD,  16'd127,  16'd127,  16'd125,  16'd127,  8'hFF, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd125, 7'd127, 4'd15, 1'b1, 1'b0}},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd126, 7'd127, 4'd15, 1'b1, 1'b0}},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd127, 7'd127, 4'd15, 1'b1, 1'b1}},
            // reversed column just off the right screen edge
            '{KIND_CMD,  16'd128,  16'd2,    16'd128,  16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd0, 7'd0, 4'd0, 1'b0, 1'b0}},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd0, 7'd0, 4'd0, 1'b0, 1'b1}},
            // full-range diagonal, then replaced mid-line by the opposite diagonal
            '{KIND_CMD,  16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h5A, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd0, 7'd0, 4'd10, 1'b0, 1'b0}},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_CMD,  16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'h80, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b1,
              '{7'd0, 7'd0, 4'd0, 1'b0, 1'b0}},
            // short shallow line run to its end
            '{KIND_CMD,  16'd0,    16'd0,    16'd3,    16'd1,    8'h07, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            // upward column, stepped in ascending order
            '{KIND_CMD,  16'd10,   16'd20,   16'd10,   16'd18,   8'h0C, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0},
            '{KIND_TICK, 16'd0,    16'd0,    16'd0,    16'd0,    8'h00, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].kind, dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1,
                      dir_rows[i].y1, dir_rows[i].pen, dir_rows[i].typed, dir_rows[i].want,
                      got);

        for (int p = 1; p <= PHASES; p++)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            // Phase 1 sets low extremes, phase 2 high ones (clips 0 or 128); later, random.
            for (int r = REG_PALETTE; r <= REG_CLIP_BOTTOM; r++)
            begin
                if (p <= 2 || $urandom_range(0, 1) == 1)
                begin
                    case (r[CFG_IDX_BITS-1:0])
                        REG_PALETTE:
                            value = (p == 1) ? '0 : (p == 2) ? '1 : {$urandom, $urandom};
                        REG_CAMERA_X, REG_CAMERA_Y:
                            if (p == 1)
                                value = 64'h8000;
                            else if (p == 2 || $urandom_range(0, 9) == 0)
                                value = 64'h7FFF;
                            else
                                value = {48'd0, 16'(int'($urandom_range(0, 80)) - 40)};
                        REG_CLIP_LEFT, REG_CLIP_TOP:
                            if (p <= 2 || $urandom_range(0, 4) == 0)
                                value = (p == 1 || $urandom_range(0, 1) == 0) ? 64'd0 : 64'd128;
                            else
                                value = 64'($urandom_range(0, 40));
                        default:
                            if (p <= 2 || $urandom_range(0, 4) == 0)
                                value = (p == 1 || $urandom_range(0, 1) == 0) ? 64'd0 : 64'd128;
                            else
                                value = 64'($urandom_range(80, 128));
                    endcase
                    write_reg(r[CFG_IDX_BITS-1:0], value);
                end
            end
            cfg_valid <= 1'b0;
            words = 0;
            while (words < PHASE_WORDS)
                random_line(words);
        end

        settle();
        if (fail_count == 0)
            $display("[clipped_line_rasterizer] OK");
        else
            $display("[clipped_line_rasterizer] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/clr_pkg.sv
design/clr_config_regs.sv
design/clr_stepper.sv
design/clr_pixel_map.sv
design/clipped_line_rasterizer.sv
tb/tb_clipped_line_rasterizer.sv
